@@ hw/rtl/vector3_normalize_macros.svh @@
// ---------------------------------------------------------------------------
// vector3_normalize_macros: assertion macros
// Shorthand for the concurrent checks in the normalizer RTL.
// ---------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_MACROS_SVH
`define VECTOR3_NORMALIZE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define VN_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector3_normalize check failed");

// Next-cycle implication, sampled on clk, off during reset
`define VN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector3_normalize check failed");

`endif

@@ hw/rtl/vn_pkg.sv @@
// ---------------------------------------------------------------------------
// vn_pkg: shared constants and types
// Widths of the fixed-point fields and the side data carried down the pipe.
// ---------------------------------------------------------------------------
package vn_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_W     = 32;
  localparam int SUM_W      = 2 * WORD_W;
  localparam int ROOT_W     = WORD_W;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int UNIT_W     = FRAC_BITS + 2;
  localparam int QUOT_W     = FRAC_BITS + 1;
  localparam int DVD_W      = WORD_W + FRAC_BITS;
  localparam int LANES      = 3;

  // Component data that rides along with each word
  typedef struct packed {
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][WORD_W-1:0] a;
  } vn_side_t;

endpackage

@@ hw/rtl/vn_in_if.sv @@
// ---------------------------------------------------------------------------
// vn_in_if: input vector channel
// Valid/ready channel carrying one Q16.16 vector per word.
// ---------------------------------------------------------------------------
interface vn_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [vn_pkg::WORD_W-1:0]  x_in;
  logic signed [vn_pkg::WORD_W-1:0]  y_in;
  logic signed [vn_pkg::WORD_W-1:0]  z_in;

  modport source (output valid, x_in, y_in, z_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, output ready);
endinterface

@@ hw/rtl/vn_out_if.sv @@
// ---------------------------------------------------------------------------
// vn_out_if: result channel
// Valid/ready channel carrying the unit vector and magnitude per word.
// ---------------------------------------------------------------------------
interface vn_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [vn_pkg::UNIT_W-1:0]  x_unit;
  logic signed [vn_pkg::UNIT_W-1:0]  y_unit;
  logic signed [vn_pkg::UNIT_W-1:0]  z_unit;
  logic        [vn_pkg::WORD_W-1:0]  magnitude;
  logic                              zero_vector;

  modport source (output valid, x_unit, y_unit, z_unit, magnitude, zero_vector,
                  input ready);
  modport sink   (input valid, x_unit, y_unit, z_unit, magnitude, zero_vector,
                  output ready);
endinterface

@@ hw/rtl/vn_square.sv @@
// ---------------------------------------------------------------------------
// vn_square: absolute value, squares and exact sum
// Three stages: abs, one multiplier per lane, 64-bit sum of squares.
// ---------------------------------------------------------------------------
module vn_square (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          adv,
  input  logic                                          in_valid,
  input  logic [vn_pkg::LANES-1:0][vn_pkg::WORD_W-1:0]  comp,
  output logic                                          out_valid,
  output vn_pkg::vn_side_t                              side,
  output logic [vn_pkg::SUM_W-1:0]                      sum
);

  logic                                         v1, v2;
  vn_pkg::vn_side_t                             side1, side2;
  logic [vn_pkg::LANES-1:0][vn_pkg::SUM_W-1:0]  prod;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Stage 1: split sign and magnitude; stage 2: square each lane
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < vn_pkg::LANES; l++) begin
        side1.neg[l] <= comp[l][vn_pkg::WORD_W-1];
        side1.a[l]   <= comp[l][vn_pkg::WORD_W-1] ? (~comp[l] + 1'b1) : comp[l];
        prod[l]      <= vn_pkg::SUM_W'(side1.a[l]) * vn_pkg::SUM_W'(side1.a[l]);
      end
    end
  end

  // Stage 3: sum of squares, never exceeds three times 2^62
  always_ff @(posedge clk) begin
    if (adv) begin
      side2 <= side1;
      side  <= side2;
      sum   <= prod[0] + prod[1] + prod[2];
    end
  end

endmodule

@@ hw/rtl/vn_sqrt.sv @@
// ---------------------------------------------------------------------------
// vn_sqrt: pipelined floor square root
// One result bit per stage, two radicand bits consumed per stage.
// ---------------------------------------------------------------------------
module vn_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  vn_pkg::vn_side_t                 in_side,
  input  logic [vn_pkg::SUM_W-1:0]         radicand,
  output logic                             out_valid,
  output vn_pkg::vn_side_t                 out_side,
  output logic [vn_pkg::ROOT_W-1:0]        root
);

  localparam int S = vn_pkg::SQRT_STEPS;

  logic                              vld  [0:S];
  vn_pkg::vn_side_t                  sd   [0:S];
  logic [vn_pkg::SUM_W-1:0]          rad  [0:S];
  logic [vn_pkg::REM_W-1:0]          rem  [0:S];
  logic [vn_pkg::ROOT_W-1:0]         rt   [0:S];

  assign vld[0] = in_valid;
  assign sd[0]  = in_side;
  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  for (genvar s = 0; s < S; s++) begin : g_step
    logic [vn_pkg::REM_W-1:0] cur, trial;
    logic                     ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[s][vn_pkg::REM_W-3:0], rad[s][vn_pkg::SUM_W-1 -: 2]};
      trial = {rt[s], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd[s+1]  <= sd[s];
        rad[s+1] <= rad[s] << 2;
        rem[s+1] <= ge ? (cur - trial) : cur;
        rt[s+1]  <= {rt[s][vn_pkg::ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = vld[S];
  assign out_side  = sd[S];
  assign root      = rt[S];

endmodule

@@ hw/rtl/vn_div.sv @@
// ---------------------------------------------------------------------------
// vn_div: pipelined restoring dividers, one per lane
// Computes (|c| << FRAC_BITS) / magnitude, one quotient bit per stage.
// ---------------------------------------------------------------------------
module vn_div (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           adv,
  input  logic                                           in_valid,
  input  vn_pkg::vn_side_t                               in_side,
  input  logic [vn_pkg::ROOT_W-1:0]                      in_mag,
  output logic                                           out_valid,
  output logic [vn_pkg::LANES-1:0]                       out_neg,
  output logic [vn_pkg::ROOT_W-1:0]                      out_mag,
  output logic [vn_pkg::LANES-1:0][vn_pkg::QUOT_W-1:0]   quot
);

  localparam int Q  = vn_pkg::QUOT_W;
  localparam int RW = vn_pkg::WORD_W + 1;

  logic                                        vld [0:Q];
  logic [vn_pkg::LANES-1:0]                    ng  [0:Q];
  logic [vn_pkg::ROOT_W-1:0]                   mg  [0:Q];
  logic [vn_pkg::LANES-1:0][RW-1:0]            rr  [0:Q];
  logic [vn_pkg::LANES-1:0][Q-1:0]             dd  [0:Q];
  logic [vn_pkg::LANES-1:0][Q-1:0]             qq  [0:Q];
  logic [vn_pkg::LANES-1:0][vn_pkg::DVD_W-1:0] dvd;

  assign vld[0] = in_valid;
  assign ng[0]  = in_side.neg;
  assign mg[0]  = in_mag;

  // Seed each lane: the upper dividend bits are already below the divisor
  always_comb begin
    for (int l = 0; l < vn_pkg::LANES; l++) begin
      dvd[l]   = {in_side.a[l], {vn_pkg::FRAC_BITS{1'b0}}};
      rr[0][l] = RW'(dvd[l][vn_pkg::DVD_W-1:Q]);
      dd[0][l] = dvd[l][Q-1:0];
      qq[0][l] = '0;
    end
  end

  for (genvar s = 0; s < Q; s++) begin : g_step
    logic [vn_pkg::LANES-1:0][RW-1:0] cur;
    logic [vn_pkg::LANES-1:0]         ge;

    // Shift in the next dividend bit and subtract if it fits
    always_comb begin
      for (int l = 0; l < vn_pkg::LANES; l++) begin
        cur[l] = {rr[s][l][RW-2:0], dd[s][l][Q-1]};
        ge[l]  = (cur[l] >= RW'(mg[s]));
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ng[s+1] <= ng[s];
        mg[s+1] <= mg[s];
        for (int l = 0; l < vn_pkg::LANES; l++) begin
          rr[s+1][l] <= ge[l] ? (cur[l] - RW'(mg[s])) : cur[l];
          dd[s+1][l] <= dd[s][l] << 1;
          qq[s+1][l] <= {qq[s][l][Q-2:0], ge[l]};
        end
      end
    end
  end

  assign out_valid = vld[Q];
  assign out_neg   = ng[Q];
  assign out_mag   = mg[Q];
  assign quot      = qq[Q];

endmodule

@@ hw/rtl/vector3_normalize.sv @@
// ---------------------------------------------------------------------------
// vector3_normalize: Q16.16 vector magnitude and unit vector
// Pipeline of squaring, square root, three dividers and an output register.
// ---------------------------------------------------------------------------
// Takes one vector word per cycle while the sink keeps up and returns one
// result word per vector, in order. Each vector passes through abs/square/sum,
// the square root (one root bit per stage), the dividers (one quotient bit per
// stage) and then the output register. The whole pipe advances together
// whenever the output register is empty or being taken, so throughput is
// one vector per cycle while the sink keeps up. A zero vector returns zero
// components, zero magnitude and zero_vector set.
module vector3_normalize (
  input  logic      clk,
  input  logic      rst,
  vn_in_if.sink     vec_in,
  vn_out_if.source  vec_out
);

  `include "vector3_normalize_macros.svh"

  localparam logic signed [vn_pkg::UNIT_W-1:0] UNIT_ONE =
    vn_pkg::UNIT_W'(1) << vn_pkg::FRAC_BITS;

  logic                                                 adv;
  logic                                                 sq_valid, rt_valid, dv_valid;
  vn_pkg::vn_side_t                                     sq_side, rt_side;
  logic [vn_pkg::SUM_W-1:0]                             sq_sum;
  logic [vn_pkg::ROOT_W-1:0]                            rt_root, dv_mag;
  logic [vn_pkg::LANES-1:0]                             dv_neg;
  logic [vn_pkg::LANES-1:0][vn_pkg::QUOT_W-1:0]         dv_quot;
  logic [vn_pkg::LANES-1:0][vn_pkg::UNIT_W-1:0]         unit_next;
  logic                                                 zero_next;

  // Move the whole pipe when the output register can take a word
  assign adv          = !vec_out.valid || vec_out.ready;
  assign vec_in.ready = adv;

  vn_square u_square (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vec_in.valid),
    .comp      ({vec_in.z_in, vec_in.y_in, vec_in.x_in}),
    .out_valid (sq_valid),
    .side      (sq_side),
    .sum       (sq_sum)
  );

  vn_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sq_valid),
    .in_side   (sq_side),
    .radicand  (sq_sum),
    .out_valid (rt_valid),
    .out_side  (rt_side),
    .root      (rt_root)
  );

  vn_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (rt_valid),
    .in_side   (rt_side),
    .in_mag    (rt_root),
    .out_valid (dv_valid),
    .out_neg   (dv_neg),
    .out_mag   (dv_mag),
    .quot      (dv_quot)
  );

  // Apply sign, force zero for a zero vector
  always_comb begin
    zero_next = (dv_mag == '0);
    for (int l = 0; l < vn_pkg::LANES; l++) begin
      if (zero_next) begin
        unit_next[l] = '0;
      end else if (dv_neg[l]) begin
        unit_next[l] = -vn_pkg::UNIT_W'(dv_quot[l]);
      end else begin
        unit_next[l] = vn_pkg::UNIT_W'(dv_quot[l]);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vec_out.valid <= 1'b0;
    end else if (adv) begin
      vec_out.valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      vec_out.x_unit      <= unit_next[0];
      vec_out.y_unit      <= unit_next[1];
      vec_out.z_unit      <= unit_next[2];
      vec_out.magnitude   <= dv_mag;
      vec_out.zero_vector <= zero_next;
    end
  end

  `VN_ASSERT_IMPL(a_zero_mag, vec_out.valid && vec_out.zero_vector, vec_out.magnitude == '0)
  `VN_ASSERT_IMPL(a_zero_units, vec_out.valid && vec_out.zero_vector,
                  vec_out.x_unit == '0 && vec_out.y_unit == '0 && vec_out.z_unit == '0)
  `VN_ASSERT_IMPL(a_mag_flag, vec_out.valid && vec_out.magnitude != '0, !vec_out.zero_vector)
  `VN_ASSERT_IMPL(a_x_range, vec_out.valid,
                  vec_out.x_unit <= UNIT_ONE && vec_out.x_unit >= -UNIT_ONE)
  `VN_ASSERT_NEXT(a_stall_hold, vec_out.valid && !vec_out.ready,
                  vec_out.valid && $stable(vec_out.magnitude))

endmodule

@@ sim/vector3_normalize_test.sv @@
// ---------------------------------------------------------------------------
// vector3_normalize_test: self-checking bench for the vector normalizer
// Drives Q16.16 vectors through the valid/ready input channel, predicts the
// magnitude and unit vector of each accepted word and checks every result
// word in order, under several patterns of sender idling and sink stalls.
// ---------------------------------------------------------------------------
module vector3_normalize_test;

  typedef struct packed {
    logic [vn_pkg::UNIT_W-1:0] x_unit;
    logic [vn_pkg::UNIT_W-1:0] y_unit;
    logic [vn_pkg::UNIT_W-1:0] z_unit;
    logic [vn_pkg::WORD_W-1:0] magnitude;
    logic                      zero_vector;
  } norm_t;

  typedef struct {
    logic [vn_pkg::WORD_W-1:0] x, y, z;
    bit                        typed;
    norm_t                     res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  vn_in_if  vec_in ();
  vn_out_if vec_out ();

  vector3_normalize dut (
    .clk     (clk),
    .rst     (rst),
    .vec_in  (vec_in.sink),
    .vec_out (vec_out.source)
  );

  norm_t pending_norms[$];
  int    errors = 0;
  int    words_out = 0;
  int    zero_seen = 0;
  int    neg_seen = 0;
  int    idle_pct = 0;
  int    stall_pct = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Floor square root, two bits of the radicand per step
  function automatic logic [vn_pkg::WORD_W-1:0] floor_root(logic [vn_pkg::SUM_W-1:0] n);
    logic [vn_pkg::SUM_W-1:0] rem, root, bit_w;
    rem = n;
    root = '0;
    bit_w = 64'h1 << 62;
    while (bit_w > rem) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (rem >= root + bit_w) begin
        rem = rem - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root = root >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return root[vn_pkg::WORD_W-1:0];
  endfunction

  function automatic logic [vn_pkg::UNIT_W-1:0] scaled_quot(logic [vn_pkg::WORD_W-1:0] c,
                                                            logic [vn_pkg::WORD_W-1:0] mag);
    logic [vn_pkg::SUM_W-1:0] a, q;
    a = c[vn_pkg::WORD_W-1] ? {32'h0, -c} : {32'h0, c};
    q = (a << vn_pkg::FRAC_BITS) / {32'h0, mag};
    if (c[vn_pkg::WORD_W-1]) q = -q;
    return q[vn_pkg::UNIT_W-1:0];
  endfunction

  function automatic norm_t normalize(logic [vn_pkg::WORD_W-1:0] x, y, z);
    logic [vn_pkg::SUM_W-1:0] ax, ay, az, sum;
    norm_t r;
    ax = x[vn_pkg::WORD_W-1] ? {32'h0, -x} : {32'h0, x};
    ay = y[vn_pkg::WORD_W-1] ? {32'h0, -y} : {32'h0, y};
    az = z[vn_pkg::WORD_W-1] ? {32'h0, -z} : {32'h0, z};
    sum = ax * ax + ay * ay + az * az;
    r.magnitude = floor_root(sum);
    if (r.magnitude == 0) begin
      r = '0;
      r.zero_vector = 1'b1;
    end else begin
      r.x_unit = scaled_quot(x, r.magnitude);
      r.y_unit = scaled_quot(y, r.magnitude);
      r.z_unit = scaled_quot(z, r.magnitude);
      r.zero_vector = 1'b0;
    end
    return r;
  endfunction

  // Offer one word, with a random gap first, and log it once taken
  task automatic send_vector(logic [vn_pkg::WORD_W-1:0] x, y, z, bit typed, norm_t res);
    while ($urandom_range(99) < idle_pct) begin
      vec_in.valid = 1'b0;
      @(negedge clk);
    end
    vec_in.x_in = x;
    vec_in.y_in = y;
    vec_in.z_in = z;
    vec_in.valid = 1'b1;
    do @(posedge clk); while (!vec_in.ready);
    pending_norms.push_back(typed ? res : normalize(x, y, z));
    @(negedge clk);
  endtask

  // Random component: full range, small, signed power of two, extreme or right-shifted random
  function automatic logic [vn_pkg::WORD_W-1:0] rand_comp();
    case ($urandom_range(5))
      0, 1: return $urandom;
      2: return $urandom_range(200) - 100;
      3: return ($urandom_range(1) ? -32'sd1 : 32'sd1) * (32'h1 << $urandom_range(30));
      4: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return $urandom >> $urandom_range(31);
    endcase
  endfunction

  // Hold ready per the current stall rate
  always @(negedge clk) begin
    vec_out.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Compare each taken result word with the oldest prediction
  always @(posedge clk) begin
    norm_t want;
    if (!rst && vec_out.valid && vec_out.ready) begin
      words_out++;
      if (vec_out.zero_vector) zero_seen++;
      if (vec_out.x_unit[vn_pkg::UNIT_W-1]) neg_seen++;
      if (pending_norms.size() == 0) begin
        $error("result word with no vector pending");
        errors++;
      end else begin
        want = pending_norms.pop_front();
        if (vec_out.x_unit !== want.x_unit) begin
          $error("x_unit: expected %0d, got %0d", $signed(want.x_unit), vec_out.x_unit);
          errors++;
        end
        if (vec_out.y_unit !== want.y_unit) begin
          $error("y_unit: expected %0d, got %0d", $signed(want.y_unit), vec_out.y_unit);
          errors++;
        end
        if (vec_out.z_unit !== want.z_unit) begin
          $error("z_unit: expected %0d, got %0d", $signed(want.z_unit), vec_out.z_unit);
          errors++;
        end
        if (vec_out.magnitude !== want.magnitude) begin
          $error("magnitude: expected %0d, got %0d", want.magnitude, vec_out.magnitude);
          errors++;
        end
        if (vec_out.zero_vector !== want.zero_vector) begin
          $error("zero_vector: expected %0b, got %0b", want.zero_vector,
                 vec_out.zero_vector);
          errors++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #(12 * 1000000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    vec_row_t rows[$];
    vec_row_t r;
    int wait_cycles;
    vec_in.valid = 1'b0;
    vec_in.x_in = '0;
    vec_in.y_in = '0;
    vec_in.z_in = '0;

    // Directed rows; typed results only where they are obvious
    r = '{x: 0, y: 0, z: 0, typed: 1, res: '{0, 0, 0, 0, 1}};                rows.push_back(r);
    r = '{x: 32'h10000, y: 0, z: 0, typed: 1,
          res: '{18'h10000, 0, 0, 32'h10000, 0}};                            rows.push_back(r);
    r = '{x: 0, y: -32'sh10000, z: 0, typed: 1,
          res: '{0, -18'sh10000, 0, 32'h10000, 0}};                          rows.push_back(r);
    r = '{x: 0, y: 0, z: 32'h8000_0000, typed: 1,
          res: '{0, 0, -18'sh10000, 32'h8000_0000, 0}};                      rows.push_back(r);
    r = '{x: 32'h7fff_ffff, y: 0, z: 0, typed: 0, res: '0};                  rows.push_back(r);
    r = '{x: 1, y: 0, z: 0, typed: 1, res: '{18'h10000, 0, 0, 1, 0}};       rows.push_back(r);
    r = '{x: 0, y: 0, z: -1, typed: 1, res: '{0, 0, -18'sh10000, 1, 0}};    rows.push_back(r);
    r = '{x: 1, y: 1, z: 1, typed: 0, res: '0};                              rows.push_back(r);
    r = '{x: 32'h7fff_ffff, y: 32'h7fff_ffff, z: 32'h7fff_ffff, typed: 0,
          res: '0};                                                          rows.push_back(r);
    r = '{x: 32'h8000_0000, y: 32'h8000_0000, z: 32'h8000_0000, typed: 0,
          res: '0};                                                          rows.push_back(r);
    r = '{x: 32'h8000_0000, y: 32'h7fff_ffff, z: 0, typed: 0, res: '0};     rows.push_back(r);
    r = '{x: -1, y: -1, z: -1, typed: 0, res: '0};                           rows.push_back(r);
    r = '{x: 32'h30000, y: 32'h40000, z: 0, typed: 0, res: '0};             rows.push_back(r);
    r = '{x: 32'h5555_5555, y: 32'haaaa_aaaa, z: 32'h0f0f_0f0f, typed: 0,
          res: '0};                                                          rows.push_back(r);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) send_vector(rows[i].x, rows[i].y, rows[i].z, rows[i].typed,
                                  rows[i].res);

    // Random words under four idling patterns
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 49 : (phase == 3) ? 20 : 0;
      stall_pct = (phase == 2) ? 49 : (phase == 3) ? 20 : 0;
      for (int n = 0; n < 375; n++) begin
        if ($urandom_range(49) == 0)
          send_vector(0, 0, 0, 0, '0);
        else
          send_vector(rand_comp(), rand_comp(), rand_comp(), 0, '0);
      end
    end
    vec_in.valid = 1'b0;

    // Drain the pipe
    wait_cycles = 0;
    while (pending_norms.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (60) @(posedge clk);
    if (pending_norms.size() != 0) begin
      $error("%0d vectors never returned a result", pending_norms.size());
      errors++;
    end

    $display("checked %0d result words (%0d zero vectors, %0d negative x)",
             words_out, zero_seen, neg_seen);
    $display("idling phases: none, sender, sink, both; %0d mismatches", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
